// ===== src/fsrm_pkg.sv =====
// Package for the shake request mixer: shared types and constants.
// No dependencies.
package fsrm_pkg;

	typedef enum logic [1:0] {
		ST_NEW     = 2'd0,
		ST_REPLACE = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_CEILING   = 2'd0,
		CFG_THRESHOLD = 2'd1,
		CFG_MIN_DUR   = 2'd2,
		CFG_MIN_HOLD  = 2'd3
	} cfg_idx_t;

	// One classified word passed from the front part to the back part.
	typedef struct packed {
		logic        tick;
		logic [47:0] key;
		logic [15:0] level;
		logic [15:0] length;
		logic [31:0] now;
	} cmd_t;

	// One result word.
	typedef struct packed {
		logic [1:0]  status;
		logic        shake_valid;
		logic [15:0] shake_level;
		logic [15:0] hold_ms;
	} res_t;

endpackage

// ===== src/fsrm_front.sv =====
// Front part: accepts input words, forms the key, raises the duration to its minimum.
// Depends on fsrm_pkg.
module fsrm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [31:0]       source_id,
	input  logic [15:0]       channel_id,
	input  logic [15:0]       level,
	input  logic [15:0]       length_ms,
	input  logic [31:0]       now_ms,
	input  logic [15:0]       min_duration_ms,
	output logic              q_valid,
	input  logic              q_pop,
	output fsrm_pkg::cmd_t    q_data
);
	fsrm_pkg::cmd_t mem_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;
	logic [15:0]    lo, len;
	fsrm_pkg::cmd_t cmd;
	logic           push;

	// A zero minimum acts as one.
	always_comb begin
		lo  = (min_duration_ms == 16'd0) ? 16'd1 : min_duration_ms;
		len = (length_ms < lo) ? lo : length_ms;
		cmd.tick   = action;
		cmd.key    = {source_id, channel_id};
		cmd.level  = level;
		cmd.length = len;
		cmd.now    = now_ms;
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rd_q];

	// Two-word queue between the front and back parts.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

// ===== src/fsrm_div.sv =====
// Restoring divider, one quotient bit per cycle: 32-bit dividend by 16-bit divisor.
// No dependencies.
module fsrm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [16:0] trial;
	logic [17:0] diff;

	always_comb begin
		trial = {rem_q[15:0], quo_q[31]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
	end

	assign quotient = quo_q;
	assign done     = busy_q && (cnt_q == 6'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= 17'd0;
			dvs_q <= divisor;
		end else if (busy_q && cnt_q != 6'd0) begin
			if (!diff[17]) begin
				rem_q <= diff[16:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
endmodule

// ===== src/fsrm_back.sv =====
// Back part: entry table, request insertion and the tick walk with its divider.
// Depends on fsrm_pkg and fsrm_div.
module fsrm_back #(
	parameter int ENTRIES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_pop,
	input  fsrm_pkg::cmd_t q_data,
	input  logic [15:0]    level_ceiling,
	input  logic [15:0]    level_threshold,
	input  logic [15:0]    min_hold_ms,
	output logic           res_valid,
	input  logic           res_stall,
	output fsrm_pkg::res_t res_data
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_READ, S_CHECK, S_DIV, S_DONE
	} state_t;

	state_t         state_q;
	fsrm_pkg::cmd_t cmd_q;
	logic [ENTRIES-1:0] valid_q;
	logic [47:0]    key_mem   [ENTRIES];
	logic [15:0]    level_mem [ENTRIES];
	logic [31:0]    start_mem [ENTRIES];
	logic [15:0]    len_mem   [ENTRIES];
	logic [CW-1:0]  idx_q;
	logic           hit_q, free_found_q;
	logic [IW-1:0]  hit_idx_q, free_idx_q;
	logic [47:0]    rkey_q;
	logic [15:0]    rlevel_q, rlen_q;
	logic [31:0]    rstart_q;
	logic [31:0]    sum_q;
	logic [15:0]    max_q, rem_q;
	logic           res_valid_q;
	fsrm_pkg::res_t res_q;
	fsrm_pkg::res_t res_c;
	logic           div_start, div_done;
	logic [31:0]    div_quo;
	logic [31:0]    elapsed;
	logic [15:0]    rem_c;
	logic [IW-1:0]  idx;
	logic [IW-1:0]  slot;
	logic [31:0]    sum_c;
	logic [15:0]    hold;
	logic           send;

	assign idx       = idx_q[IW-1:0];
	assign elapsed   = cmd_q.now - rstart_q;
	assign rem_c     = rlen_q - elapsed[15:0];
	assign div_start = (state_q == S_CHECK) && cmd_q.tick && valid_q[idx]
		&& (elapsed < {16'd0, rlen_q});
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;
	assign slot      = hit_q ? hit_idx_q : free_idx_q;
	assign sum_c     = (sum_q > {16'd0, level_ceiling}) ? {16'd0, level_ceiling} : sum_q;
	assign hold      = (max_q > min_hold_ms) ? max_q : min_hold_ms;
	assign send      = (state_q == S_DONE) && (!res_valid_q || !res_stall);

	fsrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({16'd0, rlevel_q} * {16'd0, rem_c}),
		.divisor  (rlen_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Result word for the command that has finished its walk.
	always_comb begin
		res_c = '0;
		if (cmd_q.tick) begin
			res_c.status = fsrm_pkg::ST_NEW;
			if (sum_c >= {16'd0, level_threshold}) begin
				res_c.shake_valid = 1'b1;
				res_c.shake_level = sum_c[15:0];
				res_c.hold_ms     = hold;
			end
		end else if (hit_q) begin
			res_c.status = fsrm_pkg::ST_REPLACE;
		end else if (free_found_q) begin
			res_c.status = fsrm_pkg::ST_NEW;
		end else begin
			res_c.status = fsrm_pkg::ST_FULL;
		end
	end

	// Entry memory: read one slot a cycle, write the chosen slot on insertion.
	always_ff @(posedge clk) begin
		rkey_q   <= key_mem[idx];
		rlevel_q <= level_mem[idx];
		rstart_q <= start_mem[idx];
		rlen_q   <= len_mem[idx];
		if (state_q == S_DONE && !cmd_q.tick && (hit_q || free_found_q)) begin
			key_mem[slot]   <= cmd_q.key;
			level_mem[slot] <= cmd_q.level;
			start_mem[slot] <= cmd_q.now;
			len_mem[slot]   <= cmd_q.length;
		end
	end

	// Sequencer: one slot per read, check and step state; a live, unexpired entry on a tick runs the divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			idx_q        <= '0;
			res_valid_q  <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (send) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cmd_q        <= q_data;
						idx_q        <= '0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						sum_q        <= '0;
						max_q        <= '0;
						state_q      <= S_READ;
					end
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					rem_q <= rem_c;
					if (cmd_q.tick) begin
						if (valid_q[idx] && elapsed >= {16'd0, rlen_q})
							valid_q[idx] <= 1'b0;
					end else if (valid_q[idx]) begin
						if (!hit_q && rkey_q == cmd_q.key) begin
							hit_q     <= 1'b1;
							hit_idx_q <= idx;
						end
					end else if (!free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx;
					end
					if (div_start) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_DIV: begin
					if (div_done) begin
						sum_q <= sum_q + div_quo;
						if (rem_q > max_q) max_q <= rem_q;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (idx_q == CW'(ENTRIES - 1)) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (send) begin
						res_q <= res_c;
						if (!cmd_q.tick && (hit_q || free_found_q))
							valid_q[slot] <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== src/fading_shake_request_mixer.sv =====
// Top level of the shake request mixer: configuration registers, front and back parts.
// Depends on fsrm_pkg, fsrm_front and fsrm_back.
//
// channel   handshake            payload
// input     in_valid/in_stall    action source_id channel_id level length_ms now_ms
// output    out_valid/out_stall  status shake_valid shake_level hold_ms
// config    cfg_valid/cfg_ready  cfg_index cfg_data
//
// Each word is taken from the queue, each slot then goes through read, check and
// step, and the result is issued last. On a tick, each live, unexpired entry also
// runs the bit-serial divider. Reset clears all entry valid bits at once. A stalled
// result holds the back part in its result state. The two-word queue accepts input
// while the back part works or a result is stalled, as long as it is not full.
module fading_shake_request_mixer #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [31:0] source_id,
	input  logic [15:0] channel_id,
	input  logic [15:0] level,
	input  logic [15:0] length_ms,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        shake_valid,
	output logic [15:0] shake_level,
	output logic [15:0] hold_ms,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic [15:0] ceiling_q, threshold_q, min_dur_q, min_hold_q;
	logic           q_valid, q_pop;
	fsrm_pkg::cmd_t q_data;
	fsrm_pkg::res_t res;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q   <= 16'd36045;
			threshold_q <= 16'd20;
			min_dur_q   <= 16'd10;
			min_hold_q  <= 16'd50;
		end else if (cfg_valid) begin
			unique case (fsrm_pkg::cfg_idx_t'(cfg_index))
				fsrm_pkg::CFG_CEILING:   ceiling_q   <= cfg_data;
				fsrm_pkg::CFG_THRESHOLD: threshold_q <= cfg_data;
				fsrm_pkg::CFG_MIN_DUR:   min_dur_q   <= cfg_data;
				fsrm_pkg::CFG_MIN_HOLD:  min_hold_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	fsrm_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .action, .source_id, .channel_id,
		.level, .length_ms, .now_ms,
		.min_duration_ms (min_dur_q),
		.q_valid, .q_pop, .q_data
	);

	fsrm_back #(.ENTRIES(ENTRIES)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_data,
		.level_ceiling   (ceiling_q),
		.level_threshold (threshold_q),
		.min_hold_ms     (min_hold_q),
		.res_valid       (out_valid),
		.res_stall       (out_stall),
		.res_data        (res)
	);

	assign status      = res.status;
	assign shake_valid = res.shake_valid;
	assign shake_level = res.shake_level;
	assign hold_ms     = res.hold_ms;
endmodule

// ===== src/fsrm_checker.sv =====
// Port checker for the shake request mixer, bound to the top level.
// Depends on fsrm_pkg and the top level's ports.
module fsrm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic        shake_valid,
	input logic [15:0] shake_level,
	input logic [15:0] hold_ms
);
	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(hold_ms))
		else $error("stalled word changed");

	// Status never takes the unused code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= fsrm_pkg::ST_FULL)
		else $error("bad status");

	// Only a tick word can carry shake.
	a_shake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && shake_valid |-> status == fsrm_pkg::ST_NEW)
		else $error("shake on a request word");

	// No shake means level and hold are zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !shake_valid |-> shake_level == 16'd0 && hold_ms == 16'd0)
		else $error("level without shake");
endmodule

bind fading_shake_request_mixer fsrm_checker u_fsrm_checker (
	.clk, .arst_n, .out_valid, .out_stall, .status, .shake_valid, .shake_level, .hold_ms
);

// ===== tb/tb.sv =====
// Testbench for the shake request mixer: a queued driver, a stalling monitor and a scoreboard.
// It checks every result word against a predictor of the shake table kept in this file.
// Depends on fsrm_pkg and fading_shake_request_mixer.
module tb;

	localparam int NumSlots = 16;
	localparam int WatchLimit = 20000;
	localparam int LongHold = 3000;

	typedef struct packed {
		logic        action;
		logic [31:0] source_id;
		logic [15:0] channel_id;
		logic [15:0] level;
		logic [15:0] length_ms;
		logic [31:0] now_ms;
	} request_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = 1'b0;
	logic [31:0] source_id = '0;
	logic [15:0] channel_id = '0;
	logic [15:0] level = '0;
	logic [15:0] length_ms = '0;
	logic [31:0] now_ms = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        shake_valid;
	logic [15:0] shake_level;
	logic [15:0] hold_ms;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	fading_shake_request_mixer #(.ENTRIES(NumSlots)) dut (.*);

	always #10 clk = ~clk;

	// Predicted table and register copies.
	logic        slot_live [NumSlots];
	logic [47:0] slot_key [NumSlots];
	logic [15:0] slot_level [NumSlots];
	logic [31:0] slot_start [NumSlots];
	logic [15:0] slot_length [NumSlots];
	logic [15:0] ceiling_q, threshold_q, min_dur_q, min_hold_q;

	request_word_t   pending_words[$];
	fsrm_pkg::res_t  expected_results[$];
	int            mismatches = 0;
	int            idle_cycles = 0;
	bit            stimulus_done = 1'b0;
	bit            long_hold_req = 1'b0;
	int            now_base = 0;

	// Works out one result word and updates the predicted table.
	function automatic fsrm_pkg::res_t mix_word(request_word_t w);
		fsrm_pkg::res_t r;
		logic [47:0] key;
		logic [15:0] len, floor_len;
		logic [31:0] elapsed, rem, sum, max_rem;
		int          hit, free_slot;
		r = '0;
		if (w.action) begin
			sum = 0;
			max_rem = 0;
			for (int i = 0; i < NumSlots; i++) begin
				if (slot_live[i]) begin
					elapsed = w.now_ms - slot_start[i];
					if (elapsed >= slot_length[i]) begin
						slot_live[i] = 1'b0;
					end else begin
						rem = slot_length[i] - elapsed;
						sum += (slot_level[i] * rem) / slot_length[i];
						if (rem > max_rem) max_rem = rem;
					end
				end
			end
			if (sum > ceiling_q) sum = ceiling_q;
			r.status = fsrm_pkg::ST_NEW;
			if (sum >= threshold_q) begin
				r.shake_valid = 1'b1;
				r.shake_level = sum[15:0];
				r.hold_ms = (max_rem > min_hold_q) ? max_rem[15:0] : min_hold_q;
			end
		end else begin
			key = {w.source_id, w.channel_id};
			floor_len = (min_dur_q == 0) ? 16'd1 : min_dur_q;
			len = (w.length_ms < floor_len) ? floor_len : w.length_ms;
			hit = -1;
			free_slot = -1;
			for (int i = 0; i < NumSlots; i++) begin
				if (slot_live[i]) begin
					if (hit < 0 && slot_key[i] == key) hit = i;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (hit >= 0) begin
				r.status = fsrm_pkg::ST_REPLACE;
			end else if (free_slot >= 0) begin
				r.status = fsrm_pkg::ST_NEW;
				hit = free_slot;
			end else begin
				r.status = fsrm_pkg::ST_FULL;
			end
			if (hit >= 0) begin
				slot_live[hit] = 1'b1;
				slot_key[hit] = key;
				slot_level[hit] = w.level;
				slot_start[hit] = w.now_ms;
				slot_length[hit] = len;
			end
		end
		return r;
	endfunction

	// Driver: sends words in bursts with random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.insert(expected_results.size(),
					mix_word(pending_words.pop_front()));
			end
			if (in_valid && in_stall) begin
				// Hold the stalled word.
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				in_valid <= 1'b1;
				{action, source_id, channel_id, level, length_ms, now_ms} <= pending_words[0];
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: receiver stalls on its own pattern, with one long hold-off on request.
	int stall_phase = 0;
	int hold_count = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result word status=%0d", status);
				end else begin
					fsrm_pkg::res_t e;
					e = expected_results.pop_front();
					if (status !== e.status || shake_valid !== e.shake_valid ||
							shake_level !== e.shake_level || hold_ms !== e.hold_ms) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
								e.status, e.shake_valid, e.shake_level, e.hold_ms,
								status, shake_valid, shake_level, hold_ms);
					end
				end
			end
			if (long_hold_req && hold_count < LongHold) begin
				hold_count <= hold_count + 1;
				out_stall <= 1'b1;
			end else begin
				stall_phase <= (stall_phase + 1) % 40;
				out_stall <= (stall_phase < 20) ? 1'b0 : ($urandom_range(0, 2) == 0);
			end
		end
	end

	// Watchdog on cycles with no accepted word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
				idle_cycles <= 0;
			else if (!stimulus_done || expected_results.size() > 0)
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WatchLimit) begin
				$display("fading_shake_request_mixer test failed");
				$finish;
			end
		end
	end

	// One register write; the write channel then goes idle before the task returns.
	task automatic write_reg(fsrm_pkg::cfg_idx_t idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			fsrm_pkg::CFG_CEILING:   ceiling_q = value;
			fsrm_pkg::CFG_THRESHOLD: threshold_q = value;
			fsrm_pkg::CFG_MIN_DUR:   min_dur_q = value;
			default:                 min_hold_q = value;
		endcase
		@(posedge clk);
	endtask

	// Waits for the driver and scoreboard queues to drain, then for the block to settle.
	task automatic drain();
		while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (2 * NumSlots * 40) @(posedge clk);
	endtask

	// Appends one word to the driver's queue.
	task automatic add_word(request_word_t w);
		pending_words.insert(pending_words.size(), w);
	endtask

	function automatic request_word_t make_request(logic [31:0] src, logic [15:0] ch,
			logic [15:0] lvl, logic [15:0] len, logic [31:0] t);
		return {1'b0, src, ch, lvl, len, t};
	endfunction

	function automatic request_word_t make_tick(logic [31:0] t);
		request_word_t w;
		w = {1'b1, $urandom(), 16'($urandom()), 16'($urandom()), 16'($urandom()), t};
		return w;
	endfunction

	// Random phase: mostly requests on a small key set around a moving clock.
	task automatic random_phase(int count);
		request_word_t w;
		for (int n = 0; n < count; n++) begin
			now_base += $urandom_range(0, 40);
			if ($urandom_range(0, 2) == 0) begin
				w = make_tick(32'(now_base + $urandom_range(0, 5)));
			end else begin
				w = make_request(($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 5),
					($urandom_range(0, 5) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3)),
					16'($urandom()), ($urandom_range(0, 3) == 0) ? 16'($urandom())
					: 16'($urandom_range(0, 300)), 32'(now_base));
			end
			if ($urandom_range(0, 30) == 0) w.now_ms = $urandom();
			add_word(w);
		end
		drain();
	endtask

	initial begin
		for (int i = 0; i < NumSlots; i++) slot_live[i] = 1'b0;
		ceiling_q = 16'd36045;
		threshold_q = 16'd20;
		min_dur_q = 16'd10;
		min_hold_q = 16'd50;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: insert, replace, extremes, full table, expiry and wrap.
		add_word(make_request(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0));
		add_word(make_request(32'hFFFF_FFFF, 16'hFFFF, 16'h1000, 16'd0, 32'd0));
		add_word(make_tick(32'd3));
		add_word(make_tick(32'd10));
		for (int i = 0; i < 17; i++)
			add_word(make_request(32'(i), 16'd0, 16'hFFFF, 16'd1000, 32'hFFFF_FFF0));
		add_word(make_tick(32'hFFFF_FFF1));
		add_word(make_tick(32'h0000_0100));
		add_word(make_tick(32'h0000_0200));
		drain();

		// Zero threshold, zero minimum duration, zero minimum hold, then zero ceiling.
		write_reg(fsrm_pkg::CFG_THRESHOLD, 16'd0);
		write_reg(fsrm_pkg::CFG_MIN_DUR, 16'd0);
		write_reg(fsrm_pkg::CFG_MIN_HOLD, 16'd0);
		add_word(make_tick(32'd5));
		add_word(make_request(32'd7, 16'd7, 16'd4096, 16'd0, 32'd5));
		add_word(make_tick(32'd5));
		drain();
		write_reg(fsrm_pkg::CFG_CEILING, 16'd0);
		random_phase(60);

		// Long hold-off on the receiver while the sender keeps offering.
		write_reg(fsrm_pkg::CFG_CEILING, 16'hFFFF);
		write_reg(fsrm_pkg::CFG_THRESHOLD, 16'hFFFF);
		write_reg(fsrm_pkg::CFG_MIN_DUR, 16'hFFFF);
		write_reg(fsrm_pkg::CFG_MIN_HOLD, 16'hFFFF);
		long_hold_req = 1'b1;
		random_phase(60);

		write_reg(fsrm_pkg::CFG_CEILING, 16'd36045);
		write_reg(fsrm_pkg::CFG_THRESHOLD, 16'd20);
		write_reg(fsrm_pkg::CFG_MIN_DUR, 16'd10);
		write_reg(fsrm_pkg::CFG_MIN_HOLD, 16'd50);
		random_phase(200);

		write_reg(fsrm_pkg::CFG_CEILING, 16'($urandom()));
		write_reg(fsrm_pkg::CFG_THRESHOLD, 16'($urandom_range(0, 4000)));
		write_reg(fsrm_pkg::CFG_MIN_DUR, 16'($urandom_range(1, 200)));
		write_reg(fsrm_pkg::CFG_MIN_HOLD, 16'($urandom_range(0, 500)));
		random_phase(110);

		stimulus_done = 1'b1;
		if (mismatches == 0 && expected_results.size() == 0)
			$display("fading_shake_request_mixer test passed");
		else
			$display("fading_shake_request_mixer test failed");
		$finish;
	end
endmodule
